[rtl/core/llt_pkg.sv]
// ----------------------------------------------------------------------------
// llt_pkg
// Shared types, register indexes and constants for the lane line tracker.
// ----------------------------------------------------------------------------
package llt_pkg;

  localparam int unsigned PosW   = 12;
  localparam int unsigned CntW   = 16;
  localparam int unsigned CurvW  = 16;
  localparam int unsigned ThrW   = 15;
  localparam int unsigned SpeedW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CntW-1:0] CntMax = '1;

  // Configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgCurvThr   = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgZeroCyc   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgImgWidth  = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgIdleMin   = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgIdleMax   = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgStopSpeed = 3'd5;

  // Tracker modes
  typedef enum logic [2:0] {
    MODE_STOP       = 3'd0,
    MODE_ZERO_LEFT  = 3'd1,
    MODE_ZERO_RIGHT = 3'd2,
    MODE_LEFT       = 3'd3,
    MODE_RIGHT      = 3'd4,
    MODE_TWO        = 3'd5
  } mode_t;

  typedef struct packed {
    logic [ThrW-1:0]   curvature_threshold;
    logic [CntW-1:0]   empty_limit;
    logic [PosW-1:0]   image_width;
    logic [PosW-1:0]   idle_min_x;
    logic [PosW-1:0]   idle_max_x;
    logic [SpeedW-1:0] stop_speed;
  } cfg_t;

  typedef struct packed {
    logic [1:0]              line_count;
    logic [PosW-1:0]         cur_left_x;
    logic [PosW-1:0]         cur_right_x;
    logic [PosW-1:0]         prev_left_x;
    logic [PosW-1:0]         prev_right_x;
    logic signed [CurvW-1:0] curvature;
  } item_t;

  typedef struct packed {
    logic [PosW-1:0]   used_left_x;
    logic [PosW-1:0]   used_right_x;
    logic [2:0]        tracker_state;
    logic              speed_override_valid;
    logic [SpeedW-1:0] speed_override;
  } result_t;

endpackage

[rtl/core/llt_tracker.sv]
// ----------------------------------------------------------------------------
// llt_tracker
// Tracker mode and frame counter registers with the next-state and position
// selection logic for one frame.
// ----------------------------------------------------------------------------
module llt_tracker (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  llt_pkg::item_t   item,
  input  llt_pkg::cfg_t    cfg,
  output llt_pkg::result_t result
);

  llt_pkg::mode_t                mode_r, mode_nxt;
  logic [llt_pkg::CntW-1:0]      cnt_r, cnt_nxt;
  logic [llt_pkg::CntW-1:0]      cnt_inc;
  logic                          cnt_done;
  logic                          two;
  logic                          one;
  logic [llt_pkg::CurvW:0]       curv_ext;
  logic [llt_pkg::CurvW:0]       curv_mag;
  logic                          curv_big;
  logic [llt_pkg::PosW-1:0]      gap_left;
  logic [llt_pkg::PosW-1:0]      gap_right;
  logic                          right_turn;
  logic [llt_pkg::PosW-1:0]      ul;
  logic [llt_pkg::PosW-1:0]      ur;
  logic                          ovr;

  // Hold state, advance on each frame that moves to the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= llt_pkg::MODE_TWO;
      cnt_r  <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Saturating frame count and empty-frame limit
  assign cnt_inc  = (cnt_r == llt_pkg::CntMax) ? cnt_r : cnt_r + 1'b1;
  assign cnt_done = (cnt_inc >= cfg.empty_limit);

  assign two = item.line_count[1];
  assign one = (item.line_count == 2'd1);

  // Turn direction: curvature sign when large, otherwise the smaller gap
  assign curv_ext  = {item.curvature[llt_pkg::CurvW-1], item.curvature};
  assign curv_mag  = curv_ext[llt_pkg::CurvW] ? -curv_ext : curv_ext;
  assign curv_big  = (curv_mag > {2'b00, cfg.curvature_threshold});
  assign gap_left  = (item.cur_left_x >= item.prev_left_x) ?
                     item.cur_left_x - item.prev_left_x :
                     item.prev_left_x - item.cur_left_x;
  assign gap_right = (item.cur_right_x >= item.prev_right_x) ?
                     item.cur_right_x - item.prev_right_x :
                     item.prev_right_x - item.cur_right_x;
  assign right_turn = curv_big ? item.curvature[llt_pkg::CurvW-1]
                               : (gap_left < gap_right);

  // Next mode, counter and chosen positions
  always_comb begin
    mode_nxt = mode_r;
    cnt_nxt  = cnt_r;
    ul       = cfg.idle_min_x;
    ur       = cfg.idle_max_x;
    ovr      = 1'b0;
    if (two) begin
      ul = item.cur_left_x;
      ur = item.cur_right_x;
      if (mode_r == llt_pkg::MODE_TWO) begin
        cnt_nxt = cnt_inc;
      end else begin
        mode_nxt = llt_pkg::MODE_TWO;
        cnt_nxt  = '0;
      end
    end else begin
      case (mode_r)
        llt_pkg::MODE_TWO: begin
          if (one) begin
            cnt_nxt = '0;
            if (right_turn) begin
              ul       = item.cur_left_x;
              ur       = cfg.image_width;
              mode_nxt = llt_pkg::MODE_LEFT;
            end else begin
              ul       = '0;
              ur       = item.cur_right_x;
              mode_nxt = llt_pkg::MODE_RIGHT;
            end
          end else if (cnt_done) begin
            mode_nxt = llt_pkg::MODE_STOP;
            cnt_nxt  = '0;
          end else begin
            cnt_nxt = cnt_inc;
          end
        end
        llt_pkg::MODE_LEFT: begin
          if (one) begin
            ul      = item.cur_left_x;
            ur      = cfg.image_width;
            cnt_nxt = cnt_inc;
          end else begin
            ul       = cfg.image_width;
            ur       = cfg.image_width;
            mode_nxt = llt_pkg::MODE_ZERO_LEFT;
            cnt_nxt  = '0;
          end
        end
        llt_pkg::MODE_ZERO_LEFT: begin
          if (one) begin
            ul       = item.cur_left_x;
            ur       = cfg.image_width;
            mode_nxt = llt_pkg::MODE_LEFT;
            cnt_nxt  = '0;
          end else begin
            ul = cfg.image_width;
            ur = cfg.image_width;
            if (cnt_done) begin
              mode_nxt = llt_pkg::MODE_STOP;
              cnt_nxt  = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
        end
        llt_pkg::MODE_RIGHT: begin
          ul = '0;
          if (one) begin
            ur      = item.cur_right_x;
            cnt_nxt = cnt_inc;
          end else begin
            ur       = '0;
            mode_nxt = llt_pkg::MODE_ZERO_RIGHT;
            cnt_nxt  = '0;
          end
        end
        llt_pkg::MODE_ZERO_RIGHT: begin
          ul = '0;
          if (one) begin
            ur       = item.cur_right_x;
            mode_nxt = llt_pkg::MODE_RIGHT;
            cnt_nxt  = '0;
          end else begin
            ur = '0;
            if (cnt_done) begin
              mode_nxt = llt_pkg::MODE_STOP;
              cnt_nxt  = '0;
            end else begin
              cnt_nxt = cnt_inc;
            end
          end
        end
        default: begin
          // Stop: hold the stop mode and request the override speed
          mode_nxt = llt_pkg::MODE_STOP;
          cnt_nxt  = cnt_inc;
          ovr      = 1'b1;
        end
      endcase
    end
  end

  // Assemble the result for this frame
  always_comb begin
    result.used_left_x          = ul;
    result.used_right_x         = ur;
    result.tracker_state        = mode_nxt;
    result.speed_override_valid = ovr;
    result.speed_override       = ovr ? cfg.stop_speed : '0;
  end

endmodule

[rtl/core/lane_line_tracking_fsm_unit.sv]
// ----------------------------------------------------------------------------
// lane_line_tracking_fsm_unit
// An input beat passes the input register, then the result register.
// Throughput: one frame per cycle unless out_ready holds the result stage,
// set by the single next-state pass of the tracker between the two registers.
// Reset (rst_n low, synchronous): mode two lines, frame count zero, both
// stages empty, configuration registers at their defaults.
// ----------------------------------------------------------------------------
module lane_line_tracking_fsm_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  // configuration
  input  logic                              cfg_we,
  input  logic [llt_pkg::CfgIdxW-1:0]       cfg_idx,
  input  logic [llt_pkg::CfgDataW-1:0]      cfg_wdata,
  // input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_line_count,
  input  logic [llt_pkg::PosW-1:0]          in_cur_left_x,
  input  logic [llt_pkg::PosW-1:0]          in_cur_right_x,
  input  logic [llt_pkg::PosW-1:0]          in_prev_left_x,
  input  logic [llt_pkg::PosW-1:0]          in_prev_right_x,
  input  logic signed [llt_pkg::CurvW-1:0]  in_curvature,
  // result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [llt_pkg::PosW-1:0]          out_used_left_x,
  output logic [llt_pkg::PosW-1:0]          out_used_right_x,
  output logic [2:0]                        out_tracker_state,
  output logic                              out_speed_override_valid,
  output logic [llt_pkg::SpeedW-1:0]        out_speed_override
);

  llt_pkg::cfg_t    cfg_r;
  llt_pkg::item_t   item_r;
  logic             item_vld_r;
  llt_pkg::result_t res_r;
  llt_pkg::result_t res_calc;
  logic             res_vld_r;
  logic             advance;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.curvature_threshold <= llt_pkg::ThrW'(1024);
      cfg_r.empty_limit         <= llt_pkg::CntW'(10);
      cfg_r.image_width         <= llt_pkg::PosW'(640);
      cfg_r.idle_min_x          <= '0;
      cfg_r.idle_max_x          <= llt_pkg::PosW'(639);
      cfg_r.stop_speed          <= '0;
    end else if (cfg_we) begin
      case (cfg_idx)
        llt_pkg::CfgCurvThr:   cfg_r.curvature_threshold <= cfg_wdata[llt_pkg::ThrW-1:0];
        llt_pkg::CfgZeroCyc:   cfg_r.empty_limit         <= cfg_wdata[llt_pkg::CntW-1:0];
        llt_pkg::CfgImgWidth:  cfg_r.image_width         <= cfg_wdata[llt_pkg::PosW-1:0];
        llt_pkg::CfgIdleMin:   cfg_r.idle_min_x          <= cfg_wdata[llt_pkg::PosW-1:0];
        llt_pkg::CfgIdleMax:   cfg_r.idle_max_x          <= cfg_wdata[llt_pkg::PosW-1:0];
        llt_pkg::CfgStopSpeed: cfg_r.stop_speed          <= cfg_wdata[llt_pkg::SpeedW-1:0];
        default: ;
      endcase
    end
  end

  // Handshake: the input stage drains whenever the result stage frees up
  assign advance  = item_vld_r && (!res_vld_r || out_ready);
  assign in_ready = !item_vld_r || advance;

  // Input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else if (in_ready) begin
      item_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item_r.line_count   <= in_line_count;
      item_r.cur_left_x   <= in_cur_left_x;
      item_r.cur_right_x  <= in_cur_right_x;
      item_r.prev_left_x  <= in_prev_left_x;
      item_r.prev_right_x <= in_prev_right_x;
      item_r.curvature    <= in_curvature;
    end
  end

  llt_tracker u_tracker (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (item_r),
    .cfg     (cfg_r),
    .result  (res_calc)
  );

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      res_vld_r <= 1'b0;
    end else if (advance) begin
      res_vld_r <= 1'b1;
    end else if (out_ready) begin
      res_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_r <= res_calc;
    end
  end

  assign out_valid                = res_vld_r;
  assign out_used_left_x          = res_r.used_left_x;
  assign out_used_right_x         = res_r.used_right_x;
  assign out_tracker_state        = res_r.tracker_state;
  assign out_speed_override_valid = res_r.speed_override_valid;
  assign out_speed_override       = res_r.speed_override;

endmodule

[test/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for lane_line_tracking_fsm_unit. A scoreboard class
// tracks the steering positions, tracker mode and speed override that each
// frame beat must produce. The bench runs directed frames through every
// tracker mode, then random scenes of line-count runs under several
// register settings. It ends with a run of two-line frames at the largest
// empty-frame limit followed by a few empty frames.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import llt_pkg::*;

  // Track tracker mode and frame count, queue the expected steering results
  class steer_scoreboard;
    cfg_t            cfg;
    mode_t           mode;
    logic [CntW-1:0] dwell;
    result_t         pending_steer[$];
    int unsigned     mismatches;

    function new();
      cfg.curvature_threshold = 15'd1024;
      cfg.empty_limit         = 16'd10;
      cfg.image_width         = 12'd640;
      cfg.idle_min_x          = 12'd0;
      cfg.idle_max_x          = 12'd639;
      cfg.stop_speed          = 16'd0;
      mode       = MODE_TWO;
      dwell      = '0;
      mismatches = 0;
    endfunction

    function void set_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] data);
      case (idx)
        CfgCurvThr:   cfg.curvature_threshold = data[ThrW-1:0];
        CfgZeroCyc:   cfg.empty_limit         = data[CntW-1:0];
        CfgImgWidth:  cfg.image_width         = data[PosW-1:0];
        CfgIdleMin:   cfg.idle_min_x          = data[PosW-1:0];
        CfgIdleMax:   cfg.idle_max_x          = data[PosW-1:0];
        CfgStopSpeed: cfg.stop_speed          = data[SpeedW-1:0];
        default: ;
      endcase
    endfunction

    function void dwell_up();
      if (dwell != CntMax) dwell++;
    endfunction

    function void enter(mode_t m);
      mode  = m;
      dwell = '0;
    endfunction

    // Count an empty frame and drop to stop once the limit is reached
    function void count_toward_stop();
      dwell_up();
      if (dwell >= cfg.empty_limit) enter(MODE_STOP);
    endfunction

    function result_t predict_steer(item_t f);
      result_t r;
      logic    override;
      logic    right_turn;
      int      curv, mag, thr, dl, dr, a, b;
      r.used_left_x  = cfg.idle_min_x;
      r.used_right_x = cfg.idle_max_x;
      override = 1'b0;
      if (f.line_count >= 2'd2) begin
        r.used_left_x  = f.cur_left_x;
        r.used_right_x = f.cur_right_x;
        if (mode == MODE_TWO) dwell_up();
        else enter(MODE_TWO);
      end else if (mode == MODE_TWO) begin
        if (f.line_count == 2'd1) begin
          // Strong curvature picks the side, otherwise the steadier line wins
          curv = int'(f.curvature);
          mag  = (curv < 0) ? -curv : curv;
          thr  = int'(cfg.curvature_threshold);
          a = int'(f.cur_left_x);
          b = int'(f.prev_left_x);
          dl = (a >= b) ? a - b : b - a;
          a = int'(f.cur_right_x);
          b = int'(f.prev_right_x);
          dr = (a >= b) ? a - b : b - a;
          right_turn = (mag > thr) ? (curv < 0) : (dl < dr);
          if (right_turn) begin
            r.used_left_x  = f.cur_left_x;
            r.used_right_x = cfg.image_width;
            enter(MODE_LEFT);
          end else begin
            r.used_left_x  = '0;
            r.used_right_x = f.cur_right_x;
            enter(MODE_RIGHT);
          end
        end else begin
          count_toward_stop();
        end
      end else if (mode == MODE_LEFT || mode == MODE_ZERO_LEFT) begin
        if (f.line_count == 2'd1) begin
          r.used_left_x  = f.cur_left_x;
          r.used_right_x = cfg.image_width;
          if (mode == MODE_LEFT) dwell_up();
          else enter(MODE_LEFT);
        end else begin
          r.used_left_x  = cfg.image_width;
          r.used_right_x = cfg.image_width;
          if (mode == MODE_LEFT) enter(MODE_ZERO_LEFT);
          else count_toward_stop();
        end
      end else if (mode == MODE_RIGHT || mode == MODE_ZERO_RIGHT) begin
        if (f.line_count == 2'd1) begin
          r.used_left_x  = '0;
          r.used_right_x = f.cur_right_x;
          if (mode == MODE_RIGHT) dwell_up();
          else enter(MODE_RIGHT);
        end else begin
          r.used_left_x  = '0;
          r.used_right_x = '0;
          if (mode == MODE_RIGHT) enter(MODE_ZERO_RIGHT);
          else count_toward_stop();
        end
      end else begin
        // Stopped without two lines: hold stop and override the speed
        mode = MODE_STOP;
        dwell_up();
        override = 1'b1;
      end
      r.tracker_state        = mode;
      r.speed_override_valid = override;
      r.speed_override       = override ? cfg.stop_speed : '0;
      return r;
    endfunction

    function void note_frame(item_t f);
      pending_steer.push_back(predict_steer(f));
    endfunction

    function void compare_field(string name, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
        if (mismatches < 40) $error("%s expected %0d got %0d", name, want, got);
        mismatches++;
      end
    endfunction

    function void check_result(result_t got);
      result_t want;
      if (pending_steer.size() == 0) begin
        if (mismatches < 40)
          $error("result beat with nothing outstanding, state %0d", got.tracker_state);
        mismatches++;
        return;
      end
      want = pending_steer.pop_front();
      compare_field("used_left_x", 32'(want.used_left_x), 32'(got.used_left_x));
      compare_field("used_right_x", 32'(want.used_right_x), 32'(got.used_right_x));
      compare_field("tracker_state", 32'(want.tracker_state), 32'(got.tracker_state));
      compare_field("speed_override_valid", 32'(want.speed_override_valid),
                    32'(got.speed_override_valid));
      compare_field("speed_override", 32'(want.speed_override),
                    32'(got.speed_override));
    endfunction
  endclass

  logic                clk;
  logic                rst_n;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgDataW-1:0] cfg_wdata;
  logic                in_valid;
  logic                in_ready;
  logic [1:0]          in_line_count;
  logic [PosW-1:0]     in_cur_left_x;
  logic [PosW-1:0]     in_cur_right_x;
  logic [PosW-1:0]     in_prev_left_x;
  logic [PosW-1:0]     in_prev_right_x;
  logic signed [CurvW-1:0] in_curvature;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [PosW-1:0]     out_used_left_x;
  logic [PosW-1:0]     out_used_right_x;
  logic [2:0]          out_tracker_state;
  logic                out_speed_override_valid;
  logic [SpeedW-1:0]   out_speed_override;

  steer_scoreboard sb;

  logic        steady_sender;
  logic        quiet_receiver;
  logic [15:0] ready_pat = '1;
  logic [5:0]  ready_pat_age = '0;
  int unsigned scene_left;
  logic [1:0]  scene_lines;

  lane_line_tracking_fsm_unit uut (
    .clk                      (clk),
    .rst_n                    (rst_n),
    .cfg_we                   (cfg_we),
    .cfg_idx                  (cfg_idx),
    .cfg_wdata                (cfg_wdata),
    .in_valid                 (in_valid),
    .in_ready                 (in_ready),
    .in_line_count            (in_line_count),
    .in_cur_left_x            (in_cur_left_x),
    .in_cur_right_x           (in_cur_right_x),
    .in_prev_left_x           (in_prev_left_x),
    .in_prev_right_x          (in_prev_right_x),
    .in_curvature             (in_curvature),
    .out_valid                (out_valid),
    .out_ready                (out_ready),
    .out_used_left_x          (out_used_left_x),
    .out_used_right_x         (out_used_right_x),
    .out_tracker_state        (out_tracker_state),
    .out_speed_override_valid (out_speed_override_valid),
    .out_speed_override       (out_speed_override)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Rotate the stall pattern, reload it each time the 6-bit age counter wraps
  always @(posedge clk) begin
    if (ready_pat_age == '0) begin
      if (quiet_receiver || $urandom_range(0, 7) == 0) ready_pat <= '1;
      else if ($urandom_range(0, 2) == 0) ready_pat <= 16'($urandom);
      else ready_pat <= 16'($urandom | $urandom);
    end else begin
      ready_pat <= {ready_pat[0], ready_pat[15:1]};
    end
    ready_pat_age <= ready_pat_age + 6'd1;
    out_ready <= ready_pat[0];
  end

  // Check every result beat against the oldest expectation
  always @(posedge clk) begin
    result_t seen;
    if (rst_n && out_valid && out_ready) begin
      seen.used_left_x          = out_used_left_x;
      seen.used_right_x         = out_used_right_x;
      seen.tracker_state        = out_tracker_state;
      seen.speed_override_valid = out_speed_override_valid;
      seen.speed_override       = out_speed_override;
      sb.check_result(seen);
    end
  end

  function automatic item_t frame(logic [1:0] lc, logic [PosW-1:0] cl, logic [PosW-1:0] cr,
                                  logic [PosW-1:0] pl, logic [PosW-1:0] pr,
                                  logic [CurvW-1:0] curv);
    item_t f;
    f.line_count   = lc;
    f.cur_left_x   = cl;
    f.cur_right_x  = cr;
    f.prev_left_x  = pl;
    f.prev_right_x = pr;
    f.curvature    = curv;
    return f;
  endfunction

  // Build a frame from runs of equal line counts, with some noise frames
  function automatic item_t scene_frame();
    item_t       f;
    int unsigned pick, zc;
    int          near;
    if (scene_left == 0) begin
      pick = $urandom_range(0, 99);
      scene_lines = (pick < 40) ? 2'd2 : (pick < 70) ? 2'd1 : (pick < 95) ? 2'd0 : 2'd3;
      zc = 32'(sb.cfg.empty_limit);
      if (zc > 30) zc = 30;
      scene_left = $urandom_range(1, zc + 3);
    end
    scene_left--;
    f.line_count  = ($urandom_range(0, 9) == 0) ? 2'($urandom) : scene_lines;
    f.cur_left_x  = PosW'($urandom);
    f.cur_right_x = PosW'($urandom);
    if ($urandom_range(0, 3) == 0) begin
      f.prev_left_x  = f.cur_left_x;
      f.prev_right_x = f.cur_right_x;
    end else begin
      f.prev_left_x  = PosW'($urandom);
      f.prev_right_x = PosW'($urandom);
    end
    case ($urandom_range(0, 3))
      0: f.curvature = CurvW'($urandom);
      1: begin
        near = int'(sb.cfg.curvature_threshold) + int'($urandom_range(0, 4)) - 2;
        if ($urandom_range(0, 1) == 1) near = -near;
        f.curvature = near[CurvW-1:0];
      end
      2: begin
        case ($urandom_range(0, 3))
          0: f.curvature = 16'h8000;
          1: f.curvature = 16'h7FFF;
          2: f.curvature = 16'hFFFF;
          default: f.curvature = 16'h0000;
        endcase
      end
      default: f.curvature = CurvW'(int'($urandom_range(0, 255)) - 128);
    endcase
    return f;
  endfunction

  // Hold the beat until the block takes it, then note it
  task automatic send_frame(input item_t f);
    in_valid        <= 1'b1;
    in_line_count   <= f.line_count;
    in_cur_left_x   <= f.cur_left_x;
    in_cur_right_x  <= f.cur_right_x;
    in_prev_left_x  <= f.prev_left_x;
    in_prev_right_x <= f.prev_right_x;
    in_curvature    <= f.curvature;
    do @(posedge clk); while (!in_ready);
    sb.note_frame(f);
  endtask

  task automatic stream_frames(input int unsigned count);
    int unsigned burst_left, gap;
    burst_left = 0;
    repeat (count) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 24);
        gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      send_frame(scene_frame());
    end
  endtask

  // Drop valid and wait for every outstanding result to drain
  task automatic settle_idle();
    in_valid <= 1'b0;
    while (sb.pending_steer.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic [15:0] thr, input logic [15:0] zcl,
                              input logic [15:0] wid, input logic [15:0] imin,
                              input logic [15:0] imax, input logic [15:0] spd);
    logic [CfgDataW-1:0] vals [6];
    logic [CfgIdxW-1:0]  idxs [6];
    vals = '{thr, zcl, wid, imin, imax, spd};
    idxs = '{CfgCurvThr, CfgZeroCyc, CfgImgWidth, CfgIdleMin, CfgIdleMax, CfgStopSpeed};
    for (int k = 0; k < 6; k++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= idxs[k];
      cfg_wdata <= vals[k];
      @(posedge clk);
      sb.set_reg(idxs[k], vals[k]);
    end
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // Walk every tracker mode at the reset register values
  task automatic directed_frames();
    // two lines at field extremes, three lines counted as two
    send_frame(frame(2'd2, 12'd0, 12'd4095, 12'd4095, 12'd0, 16'h7FFF));
    send_frame(frame(2'd3, 12'd4095, 12'd0, 12'd0, 12'd4095, 16'h8000));
    // empty frame in two-lines reports the idle positions
    send_frame(frame(2'd0, 12'd100, 12'd500, 12'd100, 12'd500, 16'h0000));
    send_frame(frame(2'd2, 12'd120, 12'd520, 12'd100, 12'd500, 16'h0000));
    send_frame(frame(2'd3, 12'd130, 12'd530, 12'd120, 12'd520, 16'h0000));
    send_frame(frame(2'd2, 12'd140, 12'd540, 12'd130, 12'd530, 16'h0000));
    // empty frames finish the count carried over from two-line frames
    repeat (4) send_frame(frame(2'd0, 12'd7, 12'd9, 12'd3, 12'd5, 16'h0100));
    // stopped: override with one line and with none
    send_frame(frame(2'd1, 12'd200, 12'd300, 12'd200, 12'd300, 16'h0000));
    send_frame(frame(2'd0, 12'd200, 12'd300, 12'd200, 12'd300, 16'h0000));
    send_frame(frame(2'd2, 12'd200, 12'd400, 12'd200, 12'd400, 16'h0000));
    // strong right curvature picks the left line
    send_frame(frame(2'd1, 12'd250, 12'd400, 12'd260, 12'd400, 16'h8000));
    send_frame(frame(2'd1, 12'd255, 12'd400, 12'd250, 12'd400, 16'h0000));
    send_frame(frame(2'd0, 12'd255, 12'd400, 12'd255, 12'd400, 16'h0000));
    send_frame(frame(2'd1, 12'd260, 12'd400, 12'd255, 12'd400, 16'h0000));
    send_frame(frame(2'd2, 12'd100, 12'd500, 12'd260, 12'd400, 16'h0000));
    // curvature at the threshold with equal gaps goes to the right line
    send_frame(frame(2'd1, 12'd100, 12'd500, 12'd100, 12'd500, 16'd1024));
    send_frame(frame(2'd0, 12'd100, 12'd500, 12'd100, 12'd500, 16'h0000));
    send_frame(frame(2'd1, 12'd100, 12'd510, 12'd100, 12'd500, 16'h0000));
    send_frame(frame(2'd2, 12'd100, 12'd500, 12'd100, 12'd510, 16'h0000));
    // negative curvature at the threshold falls back to the smaller gap
    send_frame(frame(2'd1, 12'd10, 12'd100, 12'd20, 12'd400, 16'hFC00));
    send_frame(frame(2'd2, 12'd10, 12'd100, 12'd10, 12'd100, 16'h0000));
    // just above the threshold, positive: right line
    send_frame(frame(2'd1, 12'd10, 12'd100, 12'd20, 12'd400, 16'd1025));
  endtask

  initial begin
    sb = new();
    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_idx         <= '0;
    cfg_wdata       <= '0;
    in_valid        <= 1'b0;
    in_line_count   <= '0;
    in_cur_left_x   <= '0;
    in_cur_right_x  <= '0;
    in_prev_left_x  <= '0;
    in_prev_right_x <= '0;
    in_curvature    <= '0;
    steady_sender  = 1'b0;
    quiet_receiver = 1'b0;
    scene_left     = 0;
    scene_lines    = 2'd2;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed_frames();
    stream_frames(200);
    settle_idle();

    // low extremes: zero threshold and zero empty-frame limit
    program_regs(16'd0, 16'd0, 16'd1, 16'd4095, 16'd0, 16'hFFFF);
    stream_frames(200);
    settle_idle();

    // high extremes, back to back beats with no stalls
    steady_sender  = 1'b1;
    quiet_receiver = 1'b1;
    program_regs(16'd32767, 16'd1, 16'd4095, 16'd0, 16'd4095, 16'd0);
    stream_frames(200);
    settle_idle();
    steady_sender  = 1'b0;
    quiet_receiver = 1'b0;

    // random settings, unused upper data bits included
    for (int p = 0; p < 3; p++) begin
      program_regs(16'($urandom), 16'($urandom_range(0, 24)), 16'($urandom),
                   16'($urandom), 16'($urandom), 16'($urandom));
      stream_frames(200);
      settle_idle();
    end

    // largest empty-frame limit: a two-line run, then empty frames stay in two-lines
    steady_sender  = 1'b1;
    quiet_receiver = 1'b1;
    program_regs(16'($urandom), 16'hFFFF, 16'($urandom), 16'($urandom),
                 16'($urandom), 16'($urandom));
    repeat (40)
      send_frame(frame(2'd2, PosW'($urandom), PosW'($urandom), PosW'($urandom),
                       PosW'($urandom), CurvW'($urandom)));
    repeat (4)
      send_frame(frame(2'd0, PosW'($urandom), PosW'($urandom), PosW'($urandom),
                       PosW'($urandom), CurvW'($urandom)));
    settle_idle();

    if (sb.mismatches == 0 && sb.pending_steer.size() == 0) begin
      $display("PASS lane_line_tracking_fsm_unit");
    end else begin
      $display("FAIL lane_line_tracking_fsm_unit");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAIL lane_line_tracking_fsm_unit");
    $finish;
  end

endmodule
